/* rtl/delta_run_length_coord_decoder_unit_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the coordinate decoder
// Shared forms for the concurrent checks used inside the RTL modules.
// ----------------------------------------------------------------------------
`ifndef DELTA_RUN_LENGTH_COORD_DECODER_UNIT_MACROS_SVH
`define DELTA_RUN_LENGTH_COORD_DECODER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DRLCD_ASSERT_SAME(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("decoder check failed");

// The consequent must hold in the cycle after the antecedent.
`define DRLCD_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("decoder check failed");

`endif

/* rtl/drlcd_pkg.sv */
// ----------------------------------------------------------------------------
// Coordinate decoder package
// Types, codes and single-precision helper functions shared by the modules.
// ----------------------------------------------------------------------------
`default_nettype none

package drlcd_pkg;

  localparam int MAX_POINTS_DEF = 4096;
  localparam int QUEUE_DEPTH_DEF = 4;

  typedef enum logic [1:0] {
    ST_VALUE    = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_BUSY     = 2'd2
  } status_t;

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_PULL = 1'b1
  } cmd_t;

  typedef enum logic {
    REG_POINT_COUNT = 1'b0,
    REG_AXIS        = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic       cmd;
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic [31:0] coord_bits;
    logic [11:0] coord_index;
    logic [1:0]  axis_out;
    logic        last_coord;
    logic        run_pending;
    logic [1:0]  status;
  } result_t;

  typedef struct packed {
    status_t     kind;
    logic [31:0] word;
    logic [31:0] step;
    logic [12:0] index;
    logic        last;
    logic        pend;
  } job_t;

  typedef struct packed {
    logic                sign;
    logic                zero;
    logic [39:0]         mant;
    logic signed [10:0]  bexp;
  } fp_norm_t;

  localparam logic [31:0] FP_DEFAULT_NAN = 32'hFFC0_0000;

  function automatic logic [31:0] fp_quiet(logic [31:0] v);
    return v | 32'h0040_0000;
  endfunction

  function automatic logic fp_is_nan(logic [31:0] v);
    return (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
  endfunction

  function automatic logic fp_is_inf(logic [31:0] v);
    return (v[30:23] == 8'hFF) && (v[22:0] == 23'd0);
  endfunction

  function automatic logic [23:0] fp_sig(logic [31:0] v);
    return {(v[30:23] != 8'd0), v[22:0]};
  endfunction

  function automatic logic [7:0] fp_exp(logic [31:0] v);
    return (v[30:23] != 8'd0) ? v[30:23] : 8'd1;
  endfunction

  // Value is m * 2^e; the result holds m shifted up to bit 39 and its biased exponent.
  function automatic fp_norm_t fp_normalize(logic sign, logic [39:0] m,
                                            logic signed [10:0] e);
    fp_norm_t   r;
    logic [5:0] lz;
    lz = 6'd0;
    for (int i = 0; i < 40; i++) begin
      if (m[i]) begin
        lz = 6'(39 - i);
      end
    end
    r.sign = sign;
    r.zero = (m == 40'd0);
    r.mant = m << lz;
    r.bexp = e + 11'sd166 - $signed({5'd0, lz});
    return r;
  endfunction

  function automatic logic [31:0] fp_round(fp_norm_t n);
    logic [5:0]  sh;
    logic [39:0] ms;
    logic        stky;
    logic [23:0] s;
    logic        g;
    logic        st;
    logic [7:0]  ef;
    logic [30:0] mag;
    sh = 6'd0;
    ms = n.mant;
    stky = 1'b0;
    ef = n.bexp[7:0];
    if (n.bexp < 11'sd1) begin
      if (n.bexp < -11'sd38) begin
        sh = 6'd40;
      end else begin
        sh = 6'(11'sd1 - n.bexp);
      end
      ms = n.mant >> sh;
      stky = |(n.mant & ~({40{1'b1}} << sh));
      ef = 8'd0;
    end
    s = ms[39:16];
    g = ms[15];
    st = (|ms[14:0]) | stky;
    mag = {ef, s[22:0]} + 31'(g & (st | s[0]));
    if (n.zero) begin
      return {n.sign, 31'd0};
    end else if (n.bexp >= 11'sd255) begin
      return {n.sign, 8'hFF, 23'd0};
    end
    return {n.sign, mag};
  endfunction

endpackage

`default_nettype wire

/* rtl/delta_run_length_coord_decoder_unit.sv */
// One stream byte or one pull request is taken every cycle while the job queue
// has room; each value passes through the queue stage and then the six-stage
// single-precision multiply-add pipeline, and values keep following one per
// cycle while results are taken. Error results (overflow, busy) travel the same
// pipeline so order is kept.
`default_nettype none

module delta_run_length_coord_decoder_unit #(
  parameter int MAX_POINTS  = drlcd_pkg::MAX_POINTS_DEF,
  parameter int QUEUE_DEPTH = drlcd_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           item_valid,
  output logic                item_ready,
  input  drlcd_pkg::item_t    item,
  output logic                result_valid,
  input  wire logic           result_ready,
  output drlcd_pkg::result_t  result,
  input  wire logic           cfg_valid,
  output logic                cfg_ready,
  input  wire logic           cfg_index,
  input  wire logic [12:0]    cfg_data
);

  logic [12:0]     point_count;
  logic [1:0]      axis;
  logic            q_full, q_nonempty, push, pop, accept;
  drlcd_pkg::job_t job_in, job_out;

  assign cfg_ready = 1'b1;
  assign item_ready = !q_full;
  assign accept = item_valid && item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= 13'd1;
      axis <= 2'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        drlcd_pkg::REG_POINT_COUNT: point_count <= cfg_data;
        drlcd_pkg::REG_AXIS:        axis <= cfg_data[1:0];
        default: begin
        end
      endcase
    end
  end

  drlcd_front #(.MAX_POINTS(MAX_POINTS)) u_front (
    .clk(clk), .rst(rst), .accept(accept), .item(item),
    .point_count(point_count), .push(push), .job(job_in)
  );

  drlcd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst(rst), .push(push), .wdata(job_in), .full(q_full),
    .pop(pop), .rdata(job_out), .nonempty(q_nonempty)
  );

  drlcd_back u_back (
    .clk(clk), .rst(rst), .job_valid(q_nonempty), .job(job_out), .job_take(pop),
    .axis(axis), .result_valid(result_valid), .result_ready(result_ready),
    .result(result)
  );

endmodule

`default_nettype wire

/* rtl/drlcd_queue.sv */
// ----------------------------------------------------------------------------
// Decoder job queue
// Small first-in first-out store between the stream parser and the
// arithmetic pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module drlcd_queue #(
  parameter int DEPTH = drlcd_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  drlcd_pkg::job_t      wdata,
  output logic                 full,
  input  wire logic            pop,
  output drlcd_pkg::job_t      rdata,
  output logic                 nonempty
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  drlcd_pkg::job_t slots [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  function automatic logic [PtrW-1:0] bump(logic [PtrW-1:0] p);
    return (p == PtrW'(DEPTH - 1)) ? '0 : PtrW'(p + 1'b1);
  endfunction

  assign full = (count == CntW'(DEPTH));
  assign nonempty = (count != '0);
  assign rdata = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= CntW'(count + 1'b1);
      end else if (pop && !push) begin
        count <= CntW'(count - 1'b1);
      end
    end
  end

  `include "delta_run_length_coord_decoder_unit_macros.svh"

  `DRLCD_ASSERT_SAME(a_no_pop_empty, clk, rst, pop, nonempty)
  `DRLCD_ASSERT_SAME(a_no_push_full, clk, rst, push && full, pop)

endmodule

`default_nettype wire

/* rtl/drlcd_front.sv */
// ----------------------------------------------------------------------------
// Decoder front end
// Parses the byte stream and pull requests, tracks runs and positions, and
// issues one job per result into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module drlcd_front #(
  parameter int MAX_POINTS = drlcd_pkg::MAX_POINTS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          accept,
  input  drlcd_pkg::item_t   item,
  input  wire logic [12:0]   point_count,
  output logic               push,
  output drlcd_pkg::job_t    job
);

  localparam int LimW = $clog2(MAX_POINTS + 1);
  localparam int CmpW = (LimW > 14) ? LimW : 14;

  typedef enum logic [4:0] {
    PH_HEADER  = 5'b00001,
    PH_COUNT   = 5'b00010,
    PH_SKIP    = 5'b00100,
    PH_LITERAL = 5'b01000,
    PH_PULL    = 5'b10000
  } phase_t;

  phase_t      phase, phase_next;
  logic [2:0]  byte_in_word, byte_in_word_next;
  logic [31:0] base_value, base_value_next;
  logic [31:0] step_value, step_value_next;
  logic [31:0] word_assembly, word_assembly_next;
  logic [6:0]  literal_left, literal_left_next;
  logic [6:0]  repeat_left, repeat_left_next;
  logic [12:0] next_index, next_index_next;
  logic        stream_done, stream_done_next;
  logic        lit_ovf;
  logic [31:0] wa_shift;

  function automatic logic at_limit(logic [12:0] v, logic [12:0] pc);
    return (CmpW'(v) >= CmpW'(pc)) || (CmpW'(v) >= CmpW'(MAX_POINTS));
  endfunction

  always_comb begin
    phase_next = phase;
    byte_in_word_next = byte_in_word;
    base_value_next = base_value;
    step_value_next = step_value;
    word_assembly_next = word_assembly;
    literal_left_next = literal_left;
    repeat_left_next = repeat_left;
    next_index_next = next_index;
    stream_done_next = stream_done;
    lit_ovf = 1'b0;
    push = 1'b0;
    job = '0;
    job.kind = drlcd_pkg::ST_VALUE;
    job.step = step_value;
    wa_shift = {word_assembly[23:0], item.data_byte};
    if (accept) begin
      if (item.cmd == drlcd_pkg::CMD_PULL) begin
        if (phase == PH_PULL && repeat_left != 7'd0) begin
          push = 1'b1;
          if (at_limit(next_index, point_count)) begin
            repeat_left_next = 7'd0;
            stream_done_next = 1'b1;
            phase_next = PH_COUNT;
            job.kind = drlcd_pkg::ST_OVERFLOW;
          end else begin
            job.word = base_value;
            job.index = next_index;
            job.last = (14'(next_index) + 14'd1 == 14'(point_count));
            next_index_next = 13'(next_index + 13'd1);
            repeat_left_next = 7'(repeat_left - 7'd1);
            if (repeat_left_next == 7'd0) begin
              phase_next = PH_COUNT;
              if (at_limit(next_index_next, point_count)) begin
                stream_done_next = 1'b1;
              end
            end
            job.pend = (repeat_left_next != 7'd0);
          end
        end
      end else if (phase == PH_PULL) begin
        push = 1'b1;
        job.kind = drlcd_pkg::ST_BUSY;
        job.pend = 1'b1;
      end else if (!stream_done) begin
        case (phase)
          PH_HEADER: begin
            word_assembly_next = wa_shift;
            if (byte_in_word == 3'd3) begin
              base_value_next = wa_shift;
            end
            if (byte_in_word == 3'd7) begin
              step_value_next = wa_shift;
              byte_in_word_next = 3'd0;
              phase_next = PH_COUNT;
              if (at_limit(next_index, point_count)) begin
                stream_done_next = 1'b1;
              end
            end else begin
              byte_in_word_next = 3'(byte_in_word + 3'd1);
            end
          end
          PH_COUNT: begin
            byte_in_word_next = 3'd0;
            if (!item.data_byte[7]) begin
              repeat_left_next = item.data_byte[6:0];
              phase_next = PH_SKIP;
            end else begin
              literal_left_next = item.data_byte[6:0];
              if (item.data_byte[6:0] != 7'd0) begin
                phase_next = PH_LITERAL;
              end
            end
          end
          PH_SKIP: begin
            if (byte_in_word == 3'd3) begin
              byte_in_word_next = 3'd0;
              if (repeat_left != 7'd0) begin
                phase_next = PH_PULL;
              end else begin
                phase_next = PH_COUNT;
                if (at_limit(next_index, point_count)) begin
                  stream_done_next = 1'b1;
                end
              end
            end else begin
              byte_in_word_next = 3'(byte_in_word + 3'd1);
            end
          end
          PH_LITERAL: begin
            if (byte_in_word == 3'd0 && at_limit(next_index, point_count)) begin
              lit_ovf = 1'b1;
              stream_done_next = 1'b1;
              literal_left_next = 7'd0;
              phase_next = PH_COUNT;
              push = 1'b1;
              job.kind = drlcd_pkg::ST_OVERFLOW;
            end else begin
              word_assembly_next = wa_shift;
              if (byte_in_word >= 3'd3) begin
                byte_in_word_next = 3'd0;
                push = 1'b1;
                job.word = wa_shift;
                job.index = next_index;
                job.last = (14'(next_index) + 14'd1 == 14'(point_count));
                next_index_next = 13'(next_index + 13'd1);
                literal_left_next = 7'(literal_left - 7'd1);
                if (literal_left_next == 7'd0) begin
                  phase_next = PH_COUNT;
                  if (at_limit(next_index_next, point_count)) begin
                    stream_done_next = 1'b1;
                  end
                end
              end else begin
                byte_in_word_next = 3'(byte_in_word + 3'd1);
              end
            end
          end
          default: begin
            phase_next = PH_COUNT;
          end
        endcase
        if (!lit_ovf && item.last_byte) begin
          stream_done_next = 1'b1;
          if (phase_next == PH_SKIP) begin
            byte_in_word_next = 3'd0;
            phase_next = (repeat_left_next != 7'd0) ? PH_PULL : PH_COUNT;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HEADER;
      byte_in_word <= 3'd0;
      base_value <= 32'd0;
      step_value <= 32'd0;
      word_assembly <= 32'd0;
      literal_left <= 7'd0;
      repeat_left <= 7'd0;
      next_index <= 13'd0;
      stream_done <= 1'b0;
    end else begin
      phase <= phase_next;
      byte_in_word <= byte_in_word_next;
      base_value <= base_value_next;
      step_value <= step_value_next;
      word_assembly <= word_assembly_next;
      literal_left <= literal_left_next;
      repeat_left <= repeat_left_next;
      next_index <= next_index_next;
      stream_done <= stream_done_next;
    end
  end

  `include "delta_run_length_coord_decoder_unit_macros.svh"

  `DRLCD_ASSERT_SAME(a_pull_has_run, clk, rst, phase == PH_PULL, repeat_left != 7'd0)
  `DRLCD_ASSERT_NEXT(a_index_steps, clk, rst, push && job.kind == drlcd_pkg::ST_VALUE,
                     next_index == 13'($past(next_index) + 13'd1))

endmodule

`default_nettype wire

/* rtl/drlcd_back.sv */
// ----------------------------------------------------------------------------
// Decoder arithmetic back end
// Six-stage single-precision pipeline forming word + index * step with
// round to nearest even, ending in the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module drlcd_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           job_valid,
  input  drlcd_pkg::job_t     job,
  output logic                job_take,
  input  wire logic [1:0]     axis,
  output logic                result_valid,
  input  wire logic           result_ready,
  output drlcd_pkg::result_t  result
);

  typedef struct packed {
    drlcd_pkg::status_t kind;
    logic [11:0]        index;
    logic               last;
    logic               pend;
  } meta_t;

  logic en;
  logic v1, v2, v3, v4, v5, v6;
  meta_t m1, m2, m3, m4, m5, m6;

  logic [31:0]        w1, w2, w3;
  logic [36:0]        p1;
  logic signed [10:0] pe1;
  logic               ps1, pspec1, pspec2;
  logic [31:0]        pbits1, pbits2;
  drlcd_pkg::fp_norm_t pn2;
  logic [31:0]        prod3;

  logic [27:0]        r4;
  logic signed [10:0] e4, e5;
  logic               s4;
  logic               aspec4, aspec5;
  logic [31:0]        abits4, abits5;
  drlcd_pkg::fp_norm_t an5;
  logic [31:0]        sum6;

  logic [23:0] step_sig;
  logic [31:0] a_spec_bits;
  logic        a_spec;
  logic [31:0] big, lesser;
  logic [7:0]  d;
  logic [26:0] ax, bx, bsh;
  logic [27:0] rsum;

  assign en = !v6 || result_ready;
  assign job_take = job_valid && en;
  assign step_sig = drlcd_pkg::fp_sig(job.step);

  always_comb begin
    a_spec = 1'b1;
    a_spec_bits = 32'd0;
    if (drlcd_pkg::fp_is_nan(w3)) begin
      a_spec_bits = drlcd_pkg::fp_quiet(w3);
    end else if (drlcd_pkg::fp_is_nan(prod3)) begin
      a_spec_bits = drlcd_pkg::fp_quiet(prod3);
    end else if (drlcd_pkg::fp_is_inf(w3) && drlcd_pkg::fp_is_inf(prod3) &&
                 (w3[31] != prod3[31])) begin
      a_spec_bits = drlcd_pkg::FP_DEFAULT_NAN;
    end else if (drlcd_pkg::fp_is_inf(w3)) begin
      a_spec_bits = w3;
    end else if (drlcd_pkg::fp_is_inf(prod3)) begin
      a_spec_bits = prod3;
    end else begin
      a_spec = 1'b0;
    end
    if (w3[30:0] >= prod3[30:0]) begin
      big = w3;
      lesser = prod3;
    end else begin
      big = prod3;
      lesser = w3;
    end
    d = 8'(drlcd_pkg::fp_exp(big) - drlcd_pkg::fp_exp(lesser));
    ax = {drlcd_pkg::fp_sig(big), 3'b000};
    bx = {drlcd_pkg::fp_sig(lesser), 3'b000};
    if (d >= 8'd27) begin
      bsh = {26'd0, |bx};
    end else begin
      bsh = (bx >> d) | {26'd0, |(bx & ~({27{1'b1}} << d))};
    end
    if (big[31] != lesser[31]) begin
      rsum = {1'b0, ax} - {1'b0, bsh};
    end else begin
      rsum = {1'b0, ax} + {1'b0, bsh};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else if (en) begin
      v1 <= job_take;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1 <= '{kind: job.kind, index: job.index[11:0], last: job.last, pend: job.pend};
      w1 <= job.word;
      p1 <= 37'(job.index) * 37'(step_sig);
      pe1 <= $signed({3'd0, drlcd_pkg::fp_exp(job.step)}) - 11'sd150;
      ps1 <= job.step[31];
      pspec1 <= 1'b1;
      if (drlcd_pkg::fp_is_nan(job.step)) begin
        pbits1 <= drlcd_pkg::fp_quiet(job.step);
      end else if (drlcd_pkg::fp_is_inf(job.step)) begin
        pbits1 <= (job.index == 13'd0) ? drlcd_pkg::FP_DEFAULT_NAN : job.step;
      end else if (job.index == 13'd0 || step_sig == 24'd0) begin
        pbits1 <= {job.step[31], 31'd0};
      end else begin
        pspec1 <= 1'b0;
        pbits1 <= 32'd0;
      end

      m2 <= m1;
      w2 <= w1;
      pspec2 <= pspec1;
      pbits2 <= pbits1;
      pn2 <= drlcd_pkg::fp_normalize(ps1, {3'd0, p1}, pe1);

      m3 <= m2;
      w3 <= w2;
      prod3 <= pspec2 ? pbits2 : drlcd_pkg::fp_round(pn2);

      m4 <= m3;
      aspec4 <= a_spec;
      abits4 <= a_spec_bits;
      r4 <= rsum;
      e4 <= $signed({3'd0, drlcd_pkg::fp_exp(big)}) - 11'sd153;
      s4 <= (rsum == 28'd0) ? (w3[31] & prod3[31]) : big[31];

      m5 <= m4;
      aspec5 <= aspec4;
      abits5 <= abits4;
      e5 <= e4;
      an5 <= drlcd_pkg::fp_normalize(s4, {12'd0, r4}, e4);

      m6 <= m5;
      if (m5.kind != drlcd_pkg::ST_VALUE) begin
        sum6 <= 32'd0;
      end else if (aspec5) begin
        sum6 <= abits5;
      end else begin
        sum6 <= drlcd_pkg::fp_round(an5);
      end
    end
  end

  assign result_valid = v6;
  always_comb begin
    result.coord_bits = sum6;
    result.axis_out = axis;
    result.status = m6.kind;
    result.run_pending = m6.pend;
    if (m6.kind == drlcd_pkg::ST_VALUE) begin
      result.coord_index = m6.index;
      result.last_coord = m6.last;
    end else begin
      result.coord_index = 12'd0;
      result.last_coord = 1'b0;
    end
  end

  `include "delta_run_length_coord_decoder_unit_macros.svh"

  `DRLCD_ASSERT_SAME(a_error_zero, clk, rst,
                     v6 && m6.kind != drlcd_pkg::ST_VALUE, sum6 == 32'd0)
  `DRLCD_ASSERT_NEXT(a_hold_stall, clk, rst, v6 && !result_ready, v6 && $stable(sum6))

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// Coordinate decoder testbench
// Drives one delta run-length coded coordinate stream through the decoder:
// a header, repeat runs drawn out by pulls, literal runs, rejected bytes and
// stray pulls, and finally a stream that runs past the point limit.
// Every request is predicted in single precision by the scoreboard, and each
// result is compared field by field in order of arrival.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int TAIL_CYCLES = 30;
  localparam int LIMIT_MAX = 4096;

  typedef enum int {DEC_HEADER, DEC_COUNT, DEC_SKIP, DEC_LITERAL, DEC_PULL} dec_phase_t;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_ready;
  drlcd_pkg::item_t   item = '0;
  logic    result_valid;
  logic    result_ready = 1'b0;
  drlcd_pkg::result_t result;
  logic    cfg_valid = 1'b0;
  logic    cfg_ready;
  logic    cfg_index = drlcd_pkg::REG_POINT_COUNT;
  logic [12:0] cfg_data = '0;

  int hold_left = 0;
  int stall_left = 0;
  int cycles = 0;
  int n_items = 0;
  bit steady = 1'b0;

  delta_run_length_coord_decoder_unit u_dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .result_valid(result_valid), .result_ready(result_ready), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  function automatic real single_to_real(logic [31:0] v);
    real r;
    if (v[30:23] == 8'd0) begin
      r = real'(v[22:0]) * (2.0 ** -149);
      return v[31] ? -r : r;
    end
    return $bitstoreal({v[31], 11'(int'(v[30:23]) - 127 + 1023), v[22:0], 29'd0});
  endfunction

  // Rounds a double to single precision, nearest even. A double that sits
  // exactly on a midpoint is pushed the way the lost error term points.
  function automatic logic [31:0] round_to_single(real d, int err_sign);
    logic [63:0] b;
    logic [63:0] sig;
    logic [63:0] kept;
    logic [63:0] rem;
    logic [63:0] half;
    logic [30:0] mag;
    int          e;
    int          sh;
    bit          up;
    b = $realtobits(d);
    if (b[62:52] == 11'd0) begin
      return {b[63], 31'd0};
    end
    sig = {11'd0, 1'b1, b[51:0]};
    e = int'(b[62:52]) - 1023 + 127;
    sh = (e >= 1) ? 29 : 30 - e;
    if (sh > 54) begin
      sh = 54;
    end
    kept = sig >> sh;
    rem = sig & ((64'd1 << sh) - 64'd1);
    half = 64'd1 << (sh - 1);
    if (rem == half && err_sign != 0) begin
      up = (err_sign > 0) != b[63];
    end else begin
      up = (rem > half) || (rem == half && kept[0]);
    end
    if (e >= 1) begin
      mag = {8'(e), kept[22:0]};
    end else begin
      mag = 31'(kept[22:0]);
    end
    mag = mag + 31'(up);
    if (e >= 255 || mag[30:23] == 8'hFF) begin
      return {b[63], 8'hFF, 23'd0};
    end
    return {b[63], mag};
  endfunction

  class coord_scoreboard;
    int unsigned point_count = 1;
    logic [1:0]  axis_reg = 2'd0;
    dec_phase_t  phase = DEC_HEADER;
    int unsigned byte_pos = 0;
    logic [31:0] base_word = '0;
    logic [31:0] step_word = '0;
    logic [31:0] word_acc = '0;
    int unsigned literal_left = 0;
    int unsigned repeat_left = 0;
    int unsigned next_index = 0;
    bit          done = 1'b0;
    drlcd_pkg::result_t coord_q[$];
    int          errors = 0;
    int          n_values = 0;
    int          n_overflow = 0;
    int          n_busy = 0;

    function int unsigned limit();
      return (point_count > LIMIT_MAX) ? LIMIT_MAX : point_count;
    endfunction

    function void enter_count();
      phase = DEC_COUNT;
      if (next_index >= limit()) begin
        done = 1'b1;
      end
    endfunction

    function void emit(logic [31:0] bits, int unsigned idx, bit last, bit pend,
                       drlcd_pkg::status_t st);
      drlcd_pkg::result_t r;
      r.coord_bits = bits;
      r.coord_index = 12'(idx);
      r.axis_out = axis_reg;
      r.last_coord = last;
      r.run_pending = pend;
      r.status = st;
      coord_q.push_back(r);
    endfunction

    function void emit_value(logic [31:0] word, bit pend);
      logic [31:0] prod;
      real         a;
      real         p;
      real         s;
      real         bb;
      real         err;
      int unsigned idx;
      prod = round_to_single(real'(next_index) * single_to_real(step_word), 0);
      a = single_to_real(word);
      p = single_to_real(prod);
      s = a + p;
      bb = s - a;
      err = (a - (s - bb)) + (p - bb);
      idx = next_index;
      next_index = (next_index + 1) & 13'h1FFF;
      emit(round_to_single(s, (err > 0.0) ? 1 : ((err < 0.0) ? -1 : 0)), idx,
           idx + 1 == point_count, pend, drlcd_pkg::ST_VALUE);
      n_values++;
    endfunction

    function void overflow();
      done = 1'b1;
      phase = DEC_COUNT;
      emit('0, 0, 1'b0, 1'b0, drlcd_pkg::ST_OVERFLOW);
      n_overflow++;
    endfunction

    function void note_item(drlcd_pkg::item_t it);
      if (it.cmd == drlcd_pkg::CMD_PULL) begin
        if (phase != DEC_PULL || repeat_left == 0) begin
          return;
        end
        if (next_index >= limit()) begin
          repeat_left = 0;
          overflow();
          return;
        end
        repeat_left--;
        emit_value(base_word, repeat_left != 0);
        if (repeat_left == 0) begin
          enter_count();
        end
        return;
      end
      if (phase == DEC_PULL) begin
        emit('0, 0, 1'b0, 1'b1, drlcd_pkg::ST_BUSY);
        n_busy++;
        return;
      end
      if (done) begin
        return;
      end
      case (phase)
        DEC_HEADER: begin
          word_acc = {word_acc[23:0], it.data_byte};
          if (byte_pos == 3) begin
            base_word = word_acc;
          end
          if (byte_pos >= 7) begin
            step_word = word_acc;
            byte_pos = 0;
            enter_count();
          end else begin
            byte_pos++;
          end
        end
        DEC_COUNT: begin
          byte_pos = 0;
          if (it.data_byte < 8'd128) begin
            repeat_left = it.data_byte;
            phase = DEC_SKIP;
          end else begin
            literal_left = it.data_byte - 8'd128;
            if (literal_left != 0) begin
              phase = DEC_LITERAL;
            end
          end
        end
        DEC_SKIP: begin
          byte_pos++;
          if (byte_pos >= 4) begin
            byte_pos = 0;
            if (repeat_left != 0) begin
              phase = DEC_PULL;
            end else begin
              enter_count();
            end
          end
        end
        DEC_LITERAL: begin
          if (byte_pos == 0 && next_index >= limit()) begin
            literal_left = 0;
            overflow();
            return;
          end
          word_acc = {word_acc[23:0], it.data_byte};
          if (byte_pos >= 3) begin
            byte_pos = 0;
            emit_value(word_acc, 1'b0);
            literal_left = (literal_left - 1) & 7'h7F;
            if (literal_left == 0) begin
              enter_count();
            end
          end else begin
            byte_pos++;
          end
        end
        default: begin
          phase = DEC_COUNT;
        end
      endcase
      if (it.last_byte) begin
        done = 1'b1;
        if (phase == DEC_SKIP) begin
          byte_pos = 0;
          phase = (repeat_left != 0) ? DEC_PULL : DEC_COUNT;
        end
      end
    endfunction

    function void check(drlcd_pkg::result_t got);
      drlcd_pkg::result_t want;
      if (coord_q.size() == 0) begin
        $error("unexpected result %h", got);
        errors++;
        return;
      end
      want = coord_q.pop_front();
      if (got.coord_bits !== want.coord_bits) begin
        $error("coord_bits expected %h actual %h", want.coord_bits, got.coord_bits);
        errors++;
      end
      if (got.coord_index !== want.coord_index) begin
        $error("coord_index expected %0d actual %0d", want.coord_index, got.coord_index);
        errors++;
      end
      if (got.axis_out !== want.axis_out) begin
        $error("axis_out expected %0d actual %0d", want.axis_out, got.axis_out);
        errors++;
      end
      if (got.last_coord !== want.last_coord) begin
        $error("last_coord expected %0b actual %0b", want.last_coord, got.last_coord);
        errors++;
      end
      if (got.run_pending !== want.run_pending) begin
        $error("run_pending expected %0b actual %0b", want.run_pending, got.run_pending);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status expected %0d actual %0d", want.status, got.status);
        errors++;
      end
    endfunction
  endclass

  coord_scoreboard sb = new();

  initial begin
    forever begin
      #5 clk = ~clk;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (steady || r < 60) begin
      return 0;
    end
    if (r < 93) begin
      return $urandom_range(3, 1);
    end
    return $urandom_range(30, 6);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        sb.check(result);
      end
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        result_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        result_ready <= 1'b0;
      end else begin
        stall_left <= gap_len();
        result_ready <= 1'b1;
      end
    end
  end

  task automatic send(drlcd_pkg::cmd_t cmd, logic [7:0] data, logic last);
    drlcd_pkg::item_t it;
    int    g;
    it.cmd = cmd;
    it.data_byte = data;
    it.last_byte = last;
    item_valid <= 1'b1;
    item <= it;
    @(posedge clk);
    while (!item_ready) begin
      @(posedge clk);
    end
    sb.note_item(it);
    n_items++;
    g = gap_len();
    if (g > 0) begin
      item_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic push(logic [7:0] data, logic last = 1'b0);
    send(drlcd_pkg::CMD_PUSH, data, last);
  endtask

  task automatic pull(logic last = 1'b0);
    send(drlcd_pkg::CMD_PULL, 8'($urandom), last);
  endtask

  task automatic push_word(logic [31:0] w);
    for (int i = 3; i >= 0; i--) begin
      push(w[8*i +: 8]);
    end
  endtask

  task automatic write_reg(drlcd_pkg::reg_index_t idx, logic [12:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    cfg_valid <= 1'b0;
    if (idx == drlcd_pkg::REG_POINT_COUNT) begin
      sb.point_count = data;
    end else begin
      sb.axis_reg = data[1:0];
    end
  endtask

  task automatic wait_idle();
    item_valid <= 1'b0;
    while (sb.coord_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_float();
    return {1'($urandom), 8'($urandom_range(142, 112)), 23'($urandom)};
  endfunction

  task automatic drain_repeat();
    while (sb.repeat_left != 0) begin
      if ($urandom_range(99) < 12) begin
        push(8'($urandom), 1'($urandom));
      end
      pull(1'($urandom));
    end
  endtask

  initial begin
    int cnt;
    int r;
    item_valid <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_reg(drlcd_pkg::REG_POINT_COUNT, 13'h1FFF);
    write_reg(drlcd_pkg::REG_AXIS, 13'd1);

    // Header, empty runs of both kinds, a stray pull, extreme literals and a
    // short repeat run with a rejected byte in the middle.
    push_word(32'h447A_0000);
    push_word(32'hBDCC_CCCD);
    pull();
    push(8'd0);
    push_word(32'hFFFF_FFFF);
    push(8'd128);
    push(8'd130);
    push_word(32'h7F7F_FFFF);
    push_word(32'h0000_0001);
    push(8'd2);
    push_word(32'h0000_0000);
    pull(1'b1);
    push(8'hFF, 1'b1);
    pull();
    pull();

    wait_idle();
    write_reg(drlcd_pkg::REG_POINT_COUNT, 13'd4096);
    write_reg(drlcd_pkg::REG_AXIS, 13'd2);

    // Long repeat run drawn out while the result side holds off.
    push(8'd60);
    push_word($urandom);
    steady = 1'b1;
    hold_left = 400;
    while (sb.repeat_left != 0) begin
      pull();
    end
    steady = 1'b0;

    while (n_items < 1500 && sb.next_index < 3800) begin
      r = $urandom_range(99);
      if (r < 40) begin
        r = $urandom_range(99);
        cnt = (r < 4) ? 0 : ((r < 8) ? $urandom_range(127, 20) : $urandom_range(8, 1));
        push(8'(cnt));
        push_word($urandom);
        drain_repeat();
      end else if (r < 88) begin
        cnt = $urandom_range(6);
        push(8'(128 + cnt));
        for (int i = 0; i < cnt; i++) begin
          push_word(rand_float());
        end
      end else begin
        pull(1'($urandom));
      end
      if ($urandom_range(99) < 3) begin
        steady = ~steady;
      end
    end
    steady = 1'b0;

    wait_idle();
    write_reg(drlcd_pkg::REG_AXIS, 13'd3);
    write_reg(drlcd_pkg::REG_POINT_COUNT, 13'(sb.next_index + 2));

    // Literal run longer than the room left: two values, then overflow, then
    // everything after the end is ignored.
    push(8'd133);
    for (int i = 0; i < 5; i++) begin
      push_word(rand_float());
    end
    for (int i = 0; i < 6; i++) begin
      push(8'($urandom), 1'($urandom));
      pull(1'($urandom));
    end

    wait_idle();
    write_reg(drlcd_pkg::REG_POINT_COUNT, 13'd0);
    write_reg(drlcd_pkg::REG_POINT_COUNT, 13'd1);
    write_reg(drlcd_pkg::REG_AXIS, 13'd0);
    push(8'd0, 1'b1);
    pull();

    wait_idle();
    $display("Stream covered %0d requests: %0d values, %0d overflow, %0d busy results.",
             n_items, sb.n_values, sb.n_overflow, sb.n_busy);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
